// ===== src/dcpl_pkg.sv =====
// Package for the dielectric canyon path loss block: widths, constants, types.
// No dependencies; every other file uses it through scoped names.
package dcpl_pkg;

   localparam int DISTANCE_BITS = 20;
   localparam int CFG_WIDTH     = 16;
   localparam int SLOPE_WIDTH   = 7;
   localparam int LOSS_WIDTH    = 17;

   // log2 unit: six lanes, 16 squaring steps, result 6-bit exponent and Q16 fraction
   localparam int LANES      = 6;
   localparam int LOG_ITER   = 16;
   localparam int LOG_WIDTH  = 22;
   localparam int EXP_WIDTH  = 6;

   localparam int LANE_PB    = 0;
   localparam int LANE_PM    = 1;
   localparam int LANE_DIST  = 2;
   localparam int LANE_FREQ  = 3;
   localparam int LANE_C750K = 4;
   localparam int LANE_C225M = 5;

   localparam logic [63:0] QUARTER_WAVE_SQ = 64'd56250000;
   localparam logic [63:0] CONST_750K      = 64'd750000;
   localparam logic [63:0] CONST_225M      = 64'd225000000;
   localparam int          LOG2_TWO_PI_Q16 = 173768;
   localparam int          LOG10_TWO_Q24   = 5050445;

   localparam logic [SLOPE_WIDTH-1:0] NEAR_SLOPE    = 7'd18;
   localparam logic [SLOPE_WIDTH-1:0] SLOPE_DEFAULT = 7'd40;

   localparam logic [CFG_WIDTH-1:0]   CARRIER_RESET = 16'd900;
   localparam logic [CFG_WIDTH-1:0]   BASE_RESET    = 16'd3000;
   localparam logic [CFG_WIDTH-1:0]   MOBILE_RESET  = 16'd150;

   localparam logic signed [LOSS_WIDTH-1:0] LOSS_MAX = 17'sh0_FFFF;
   localparam logic signed [LOSS_WIDTH-1:0] LOSS_MIN = 17'sh1_0000;

   typedef enum logic [1:0] {
      REG_CARRIER = 2'd0,
      REG_BASE    = 2'd1,
      REG_MOBILE  = 2'd2,
      REG_SLOPE   = 2'd3
   } csr_index_type;

   typedef logic [LANES-1:0][63:0]          lane_in_type;
   typedef logic [LANES-1:0][LOG_WIDTH-1:0] lane_log_type;

   // sideband that rides alongside the log unit
   typedef struct packed {
      logic                   valid;
      logic                   bad;
      logic [SLOPE_WIDTH-1:0] slope;
   } side_type;

endpackage

// ===== src/dcpl_if.sv =====
// Request and response channel interfaces for the path loss block.
// Depends on dcpl_pkg for field widths.
interface dcpl_req_if;
   logic                              valid;
   logic                              ready;
   logic [dcpl_pkg::DISTANCE_BITS-1:0] distance_m;

   modport source (output valid, output distance_m, input ready);
   modport sink   (input valid, input distance_m, output ready);
endinterface

interface dcpl_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [dcpl_pkg::LOSS_WIDTH-1:0] loss_q8;
   logic                                  beyond_breakpoint;
   logic                                  invalid;

   modport source (output valid, output loss_q8, output beyond_breakpoint,
                   output invalid, input ready);
   modport sink   (input valid, input loss_q8, input beyond_breakpoint,
                   input invalid, output ready);
endinterface

// ===== src/dcpl_log2_pipe.sv =====
// Pipelined log2 in Q16 for six lanes: one normalise stage, then one squaring
// step per stage. Depends on dcpl_pkg.
module dcpl_log2_pipe (
   input  logic                  clock,
   input  logic                  advance,
   input  dcpl_pkg::lane_in_type x_in,
   output dcpl_pkg::lane_log_type log_out
);

   logic [dcpl_pkg::LOG_ITER:0][dcpl_pkg::LANES-1:0][dcpl_pkg::EXP_WIDTH-1:0] e_ff, e_in;
   logic [dcpl_pkg::LOG_ITER:0][dcpl_pkg::LANES-1:0][31:0]                    m_ff, m_in;
   logic [dcpl_pkg::LOG_ITER:0][dcpl_pkg::LANES-1:0][15:0]                    frac_ff, frac_in;

   always_comb begin
      logic [63:0] sq;
      logic [32:0] tq;
      e_in    = e_ff;
      m_in    = m_ff;
      frac_in = frac_ff;
      for (int l = 0; l < dcpl_pkg::LANES; l++) begin
         // leading one, then bring it to bit 31
         e_in[0][l] = '0;
         for (int i = 0; i < 64; i++) begin
            if (x_in[l][i]) begin
               e_in[0][l] = dcpl_pkg::EXP_WIDTH'(i);
            end
         end
         m_in[0][l]    = 32'({x_in[l], 31'b0} >> e_in[0][l]);
         frac_in[0][l] = '0;
      end
      for (int k = 0; k < dcpl_pkg::LOG_ITER; k++) begin
         for (int l = 0; l < dcpl_pkg::LANES; l++) begin
            sq = 64'(m_ff[k][l]) * 64'(m_ff[k][l]);
            tq = sq[63:31];
            e_in[k+1][l] = e_ff[k][l];
            if (tq[32]) begin
               m_in[k+1][l]    = tq[32:1];
               frac_in[k+1][l] = {frac_ff[k][l][14:0], 1'b1};
            end else begin
               m_in[k+1][l]    = tq[31:0];
               frac_in[k+1][l] = {frac_ff[k][l][14:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_ff    <= e_in;
         m_ff    <= m_in;
         frac_ff <= frac_in;
      end
   end

   always_comb begin
      for (int l = 0; l < dcpl_pkg::LANES; l++) begin
         log_out[l] = {e_ff[dcpl_pkg::LOG_ITER][l], frac_ff[dcpl_pkg::LOG_ITER][l]};
      end
   end

endmodule

// ===== src/dielectric_canyon_path_loss.sv =====
// Top level of the dielectric canyon path loss block.
// Depends on dcpl_pkg, dcpl_if and dcpl_log2_pipe.
//
// Usage:
//   req carries one distance in metres per request; rsp returns the loss in
//   1/256 dB with the beyond_breakpoint and invalid flags. Both are valid/ready
//   channels; a request is taken at a clock edge where valid and ready are high.
//   csr_write_enable with csr_index and csr_write_data sets carrier frequency,
//   the two antenna heights and the far slope; write only while no request is
//   in flight.
//   From request to response, three stages form the height terms (two
//   multiplies, subtract), 17 stages form six log2 values (normalise plus
//   one mantissa squaring per fraction bit), and four stages combine, scale
//   by log10(2), round and saturate. Throughput is one request per cycle
//   while no stall holds it; the whole pipeline moves together.
//   When the receiver holds rsp.ready low with a response waiting, every
//   stage holds and req.ready drops; nothing is lost or repeated.
//   Reset empties the pipeline and returns the registers to 900 MHz, 30 m,
//   1.5 m and 40 dB per decade.
module dielectric_canyon_path_loss (
   input  logic                               clock,
   input  logic                               reset,
   dcpl_req_if.sink                           req,
   dcpl_rsp_if.source                         rsp,
   input  logic                               csr_write_enable,
   input  dcpl_pkg::csr_index_type            csr_index,
   input  logic [dcpl_pkg::CFG_WIDTH-1:0]     csr_write_data
);

   localparam int R_W = 26;
   localparam int T_W = 34;
   localparam int P_W = 58;

   logic [dcpl_pkg::CFG_WIDTH-1:0]   carrier_ff, base_ff, mobile_ff;
   logic [dcpl_pkg::SLOPE_WIDTH-1:0] slope_ff;

   logic advance;

   // stage 1: height times carrier
   logic                                s1_valid_ff;
   logic [31:0]                         s1_pb_ff, s1_pm_ff;
   logic [dcpl_pkg::DISTANCE_BITS-1:0]  s1_dist_ff;
   logic [dcpl_pkg::CFG_WIDTH-1:0]      s1_freq_ff;
   logic [dcpl_pkg::SLOPE_WIDTH-1:0]    s1_slope_ff;
   // stage 2: squares
   logic                                s2_valid_ff;
   logic [63:0]                         s2_sqb_ff, s2_sqm_ff;
   logic [dcpl_pkg::DISTANCE_BITS-1:0]  s2_dist_ff;
   logic [dcpl_pkg::CFG_WIDTH-1:0]      s2_freq_ff;
   logic [dcpl_pkg::SLOPE_WIDTH-1:0]    s2_slope_ff;
   // stage 3: magnitudes and validity
   dcpl_pkg::side_type                  s3_side_ff, s3_side_in;
   logic [63:0]                         s3_magb_ff, s3_magm_ff, magb_in, magm_in;
   logic [dcpl_pkg::DISTANCE_BITS-1:0]  s3_dist_ff;
   logic [dcpl_pkg::CFG_WIDTH-1:0]      s3_freq_ff;
   // log stages
   dcpl_pkg::side_type [dcpl_pkg::LOG_ITER:0] side_ff;
   dcpl_pkg::lane_in_type               lane_x;
   dcpl_pkg::lane_log_type              lane_log;
   // combine stages
   dcpl_pkg::side_type                  r_side_ff;
   logic signed [R_W-1:0]               r2_ff, g2_ff, r2_in, g2_in;
   logic                                t_valid_ff, t_bad_ff, t_beyond_ff;
   logic signed [T_W-1:0]               t_ff, t_in;
   logic [dcpl_pkg::SLOPE_WIDTH-1:0]    slope_eff, n_sel;
   logic                                p_valid_ff, p_bad_ff, p_beyond_ff;
   logic signed [P_W-1:0]               p_ff;
   logic signed [P_W-1:0]               v_sum;
   logic signed [P_W-34:0]              q_val;
   // output register
   logic                                out_valid_ff;
   logic signed [dcpl_pkg::LOSS_WIDTH-1:0] out_loss_ff, out_loss_in;
   logic                                out_beyond_ff, out_invalid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_ff <= dcpl_pkg::CARRIER_RESET;
         base_ff    <= dcpl_pkg::BASE_RESET;
         mobile_ff  <= dcpl_pkg::MOBILE_RESET;
         slope_ff   <= dcpl_pkg::SLOPE_DEFAULT;
      end else if (csr_write_enable) begin
         case (csr_index)
            dcpl_pkg::REG_CARRIER: carrier_ff <= csr_write_data;
            dcpl_pkg::REG_BASE:    base_ff    <= csr_write_data;
            dcpl_pkg::REG_MOBILE:  mobile_ff  <= csr_write_data;
            dcpl_pkg::REG_SLOPE:   slope_ff   <= csr_write_data[dcpl_pkg::SLOPE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // move every stage together unless a response waits
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      if (s2_sqb_ff >= dcpl_pkg::QUARTER_WAVE_SQ) begin
         magb_in = s2_sqb_ff - dcpl_pkg::QUARTER_WAVE_SQ;
      end else begin
         magb_in = dcpl_pkg::QUARTER_WAVE_SQ - s2_sqb_ff;
      end
      if (s2_sqm_ff >= dcpl_pkg::QUARTER_WAVE_SQ) begin
         magm_in = s2_sqm_ff - dcpl_pkg::QUARTER_WAVE_SQ;
      end else begin
         magm_in = dcpl_pkg::QUARTER_WAVE_SQ - s2_sqm_ff;
      end
      s3_side_in.valid = s2_valid_ff;
      s3_side_in.slope = s2_slope_ff;
      s3_side_in.bad   = (s2_dist_ff == '0) || (s2_freq_ff == '0) ||
                         (magb_in == '0) || (magm_in == '0) ||
                         ((s2_sqb_ff >= dcpl_pkg::QUARTER_WAVE_SQ) !=
                          (s2_sqm_ff >= dcpl_pkg::QUARTER_WAVE_SQ));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         s3_side_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_valid_ff      <= req.valid;
         s2_valid_ff      <= s1_valid_ff;
         s3_side_ff       <= s3_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pb_ff         <= 32'(base_ff) * 32'(carrier_ff);
         s1_pm_ff         <= 32'(mobile_ff) * 32'(carrier_ff);
         s1_dist_ff       <= req.distance_m;
         s1_freq_ff       <= carrier_ff;
         s1_slope_ff      <= slope_ff;
         s2_sqb_ff        <= 64'(s1_pb_ff) * 64'(s1_pb_ff);
         s2_sqm_ff        <= 64'(s1_pm_ff) * 64'(s1_pm_ff);
         s2_dist_ff       <= s1_dist_ff;
         s2_freq_ff       <= s1_freq_ff;
         s2_slope_ff      <= s1_slope_ff;
         s3_magb_ff       <= magb_in;
         s3_magm_ff       <= magm_in;
         s3_dist_ff       <= s2_dist_ff;
         s3_freq_ff       <= s2_freq_ff;
      end
   end

   // constant lanes fold away in synthesis
   always_comb begin
      lane_x                      = '0;
      lane_x[dcpl_pkg::LANE_PB]   = s3_magb_ff;
      lane_x[dcpl_pkg::LANE_PM]   = s3_magm_ff;
      lane_x[dcpl_pkg::LANE_DIST] = 64'(s3_dist_ff);
      lane_x[dcpl_pkg::LANE_FREQ] = 64'(s3_freq_ff);
      lane_x[dcpl_pkg::LANE_C750K] = dcpl_pkg::CONST_750K;
      lane_x[dcpl_pkg::LANE_C225M] = dcpl_pkg::CONST_225M;
   end

   dcpl_log2_pipe u_log2 (
      .clock   (clock),
      .advance (advance),
      .x_in    (lane_x),
      .log_out (lane_log)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= dcpl_pkg::LOG_ITER; k++) begin
            side_ff[k] <= '0;
         end
      end else if (advance) begin
         side_ff[0] <= s3_side_ff;
         for (int k = 1; k <= dcpl_pkg::LOG_ITER; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // 2*log2(d/D) and 2*log2(2*pi*D/lambda), Q16
   always_comb begin
      logic signed [R_W-1:0] s_sum;
      logic signed [R_W-1:0] l_sum;
      s_sum = R_W'(lane_log[dcpl_pkg::LANE_PB]) + R_W'(lane_log[dcpl_pkg::LANE_PM]);
      l_sum = R_W'(lane_log[dcpl_pkg::LANE_DIST]) + R_W'(lane_log[dcpl_pkg::LANE_FREQ])
              + R_W'(lane_log[dcpl_pkg::LANE_C750K]);
      r2_in = (l_sum <<< 1) - s_sum;
      g2_in = R_W'(2 * dcpl_pkg::LOG2_TWO_PI_Q16) + s_sum
              - (R_W'(lane_log[dcpl_pkg::LANE_C225M]) <<< 1);
   end

   always_comb begin
      if (r_side_ff.slope inside {[7'd30:7'd70]}) begin
         slope_eff = r_side_ff.slope;
      end else begin
         slope_eff = dcpl_pkg::SLOPE_DEFAULT;
      end
      n_sel = (r2_ff >= 0) ? slope_eff : dcpl_pkg::NEAR_SLOPE;
      t_in  = 34'sd10 * T_W'(g2_ff) + $signed(T_W'(n_sel)) * T_W'(r2_ff);
   end

   always_comb begin
      v_sum = p_ff + (P_W'(1) <<< 32);
      q_val = v_sum[P_W-1:33];
      if (q_val > (P_W-33)'(dcpl_pkg::LOSS_MAX)) begin
         out_loss_in = dcpl_pkg::LOSS_MAX;
      end else if (q_val < (P_W-33)'(dcpl_pkg::LOSS_MIN)) begin
         out_loss_in = dcpl_pkg::LOSS_MIN;
      end else begin
         out_loss_in = q_val[dcpl_pkg::LOSS_WIDTH-1:0];
      end
      if (p_bad_ff) begin
         out_loss_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_side_ff.valid <= 1'b0;
         t_valid_ff      <= 1'b0;
         p_valid_ff      <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else if (advance) begin
         r_side_ff       <= side_ff[dcpl_pkg::LOG_ITER];
         t_valid_ff      <= r_side_ff.valid;
         p_valid_ff      <= t_valid_ff;
         out_valid_ff    <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r2_ff           <= r2_in;
         g2_ff           <= g2_in;
         t_ff            <= t_in;
         t_bad_ff        <= r_side_ff.bad;
         t_beyond_ff     <= (r2_ff >= 0);
         p_ff            <= P_W'(t_ff) * P_W'(dcpl_pkg::LOG10_TWO_Q24);
         p_bad_ff        <= t_bad_ff;
         p_beyond_ff     <= t_beyond_ff;
         out_loss_ff     <= out_loss_in;
         out_beyond_ff   <= p_beyond_ff && !p_bad_ff;
         out_invalid_ff  <= p_bad_ff;
      end
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.loss_q8           = out_loss_ff;
   assign rsp.beyond_breakpoint = out_beyond_ff;
   assign rsp.invalid           = out_invalid_ff;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> s1_valid_ff)
      else $error("accepted request did not enter the pipeline");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_invalid_ff |-> (out_loss_ff == '0) && !out_beyond_ff)
      else $error("invalid response carries a loss or breakpoint flag");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(t_valid_ff) && $stable(p_valid_ff) && $stable(t_ff))
      else $error("pipeline moved during a stall");

endmodule
